FILE: design/tfp_pkg.sv
// Shared types and constants for the tenths fixed-point ALU.
// No dependencies; imported by tfp_udiv and tenths_fixed_point_alu.
package tfp_pkg;

    localparam int WHOLE_W  = 32;
    localparam int TENTHS_W = 4;
    localparam int NUM_W    = 36;   // 10 * whole + tenths fits here
    localparam int PROD_W   = 64;
    localparam int DEC      = 10;
    localparam int DIV_BPS  = 1;    // quotient bits per stage, main divider
    localparam int DEC_BPS  = 6;    // quotient bits per stage, divide by ten

    typedef enum logic [2:0] {
        OP_ADD_VAL     = 3'd0,
        OP_ADD_INT     = 3'd1,
        OP_MUL_INT     = 3'd2,
        OP_DIV_INT     = 3'd3,
        OP_FROM_TENTHS = 3'd4
    } t_op;

    // carried alongside the main divider
    typedef struct packed {
        t_op                 op;
        logic [PROD_W-1:0]   prod;
        logic [WHOLE_W-1:0]  whole;
        logic [TENTHS_W-1:0] tenths;
        logic                ovf;
        logic                dbz;
    } t_side;

    // carried alongside the divide-by-ten stages
    typedef struct packed {
        t_side               s;
        logic [NUM_W-1:0]    q1;
        logic [TENTHS_W-1:0] rem1;
    } t_side2;

    localparam int SIDE_W  = $bits(t_side);
    localparam int SIDE2_W = $bits(t_side2);

endpackage

FILE: design/tfp_udiv.sv
// Pipelined restoring unsigned divider with a side-band payload.
// Depends on tfp_pkg for default widths.
module tfp_udiv
    import tfp_pkg::*;
#(
    parameter int NW  = NUM_W,
    parameter int DW  = WHOLE_W,
    parameter int BPS = DIV_BPS,
    parameter int SW  = SIDE_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    localparam int S = NW / BPS;

    logic          r_v    [S];
    logic [NW-1:0] r_num  [S];
    logic [DW-1:0] r_rem  [S];
    logic [DW-1:0] r_den  [S];
    logic [SW-1:0] r_side [S];

    logic          p_v    [S];
    logic [NW-1:0] p_num  [S];
    logic [DW-1:0] p_rem  [S];
    logic [DW-1:0] p_den  [S];
    logic [SW-1:0] p_side [S];
    logic [NW-1:0] n_num  [S];
    logic [DW-1:0] n_rem  [S];
    logic          rdy    [S+1];

    assign rdy[S] = i_ready;

    for (genvar k = 0; k < S; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign p_v[k]    = i_valid;
            assign p_num[k]  = i_num;
            assign p_rem[k]  = '0;
            assign p_den[k]  = i_den;
            assign p_side[k] = i_side;
        end else begin : g_next
            assign p_v[k]    = r_v[k-1];
            assign p_num[k]  = r_num[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_den[k]  = r_den[k-1];
            assign p_side[k] = r_side[k-1];
        end

        // a stage takes new data when empty or when its successor moves
        assign rdy[k] = !r_v[k] || rdy[k+1];

        logic [NW-1:0] c_num;
        logic [DW-1:0] c_rem;
        assign n_num[k] = c_num;
        assign n_rem[k] = c_rem;

        // quotient bits shift into the low end of the numerator word
        always_comb begin : step
            logic [DW:0] t;
            c_num = p_num[k];
            c_rem = p_rem[k];
            t     = '0;
            for (int j = 0; j < BPS; j++) begin
                t     = {c_rem, c_num[NW-1]};
                c_num = {c_num[NW-2:0], 1'b0};
                if (t >= {1'b0, p_den[k]}) begin
                    c_rem    = DW'(t - {1'b0, p_den[k]});
                    c_num[0] = 1'b1;
                end else begin
                    c_rem = t[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < S; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= p_v[k];
            end
            if (rdy[k] && p_v[k]) begin
                r_num[k]  <= n_num[k];
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= p_den[k];
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[S-1];
    assign o_quo   = r_num[S-1];
    assign o_rem   = r_rem[S-1];
    assign o_side  = r_side[S-1];

endmodule

FILE: design/tenths_fixed_point_alu.sv
// Top level of the tenths fixed-point ALU: operand decode, two divider
// pipelines and the result register. Depends on tfp_pkg and tfp_udiv.
//
// Accepts one transfer per clock unless back-pressure stalls it, and returns
// one result per transfer, in order. A transfer passes the front stage, the
// restoring divider (one bit per stage by default) that handles divide, the
// tenths split of multiply and the tenths count, six stages that divide by
// ten, and the result register. Every stage holds its data under back-pressure, so stalls
// on the output lose or repeat nothing and bubbles are squeezed out.
module tenths_fixed_point_alu
    import tfp_pkg::*;
#(
    parameter int DIV_BITS_PER_STAGE = DIV_BPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_whole[31:0], a_tenths[35:32], b_whole[67:36], b_tenths[71:68],
    // scalar[103:72]
    input  logic [103:0] i_s_axis_tdata,
    // op[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // r_whole[31:0], r_tenths[35:32], zero[39:36]
    output logic [39:0]  o_m_axis_tdata,
    // overflow[0], divide_by_zero[1]
    output logic [1:0]   o_m_axis_tuser
);

    logic [WHOLE_W-1:0]  aw, bw, sc;
    logic [TENTHS_W-1:0] at, bt;
    t_op                 op;

    assign aw = i_s_axis_tdata[31:0];
    assign at = i_s_axis_tdata[35:32];
    assign bw = i_s_axis_tdata[67:36];
    assign bt = i_s_axis_tdata[71:68];
    assign sc = i_s_axis_tdata[103:72];
    assign op = t_op'(i_s_axis_tuser);

    // front stage
    logic               r_a_v;
    logic [NUM_W-1:0]   r_a_num, n_a_num;
    logic [WHOLE_W-1:0] r_a_den, n_a_den;
    t_side              r_a_side, n_a_side;
    logic               d1_rdy;

    always_comb begin
        logic [4:0]         s;
        logic [1:0]         c;
        logic [WHOLE_W+1:0] w;
        s        = 5'(at) + 5'(bt);
        c        = '0;
        w        = '0;
        n_a_num  = '0;
        n_a_den  = WHOLE_W'(1);
        n_a_side = '0;
        n_a_side.op = op;
        case (op)
            OP_ADD_VAL: begin
                // two out-of-range digits can carry up to three
                if (s >= 5'd30) begin
                    c = 2'd3;
                end else if (s >= 5'd20) begin
                    c = 2'd2;
                end else if (s >= 5'(DEC)) begin
                    c = 2'd1;
                end
                w = (WHOLE_W+2)'(aw) + (WHOLE_W+2)'(bw) + (WHOLE_W+2)'(c);
                n_a_side.whole  = w[WHOLE_W-1:0];
                n_a_side.tenths = TENTHS_W'(s - 5'(c) * 5'(DEC));
                n_a_side.ovf    = |w[WHOLE_W+1:WHOLE_W];
            end
            OP_ADD_INT: begin
                c = {1'b0, at >= TENTHS_W'(DEC)};
                w = (WHOLE_W+2)'(aw) + (WHOLE_W+2)'(sc) + (WHOLE_W+2)'(c);
                n_a_side.whole  = w[WHOLE_W-1:0];
                n_a_side.tenths = at - (c[0] ? TENTHS_W'(DEC) : '0);
                n_a_side.ovf    = |w[WHOLE_W+1:WHOLE_W];
            end
            OP_MUL_INT: begin
                n_a_num       = NUM_W'(at) * NUM_W'(sc);
                n_a_den       = WHOLE_W'(DEC);
                n_a_side.prod = PROD_W'(aw) * PROD_W'(sc);
            end
            OP_DIV_INT: begin
                n_a_num      = (NUM_W'(aw) << 3) + (NUM_W'(aw) << 1) + NUM_W'(at);
                n_a_den      = sc;
                n_a_side.dbz = (sc == '0);
            end
            OP_FROM_TENTHS: begin
                n_a_num = NUM_W'(sc);
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = !r_a_v || d1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_a_v <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_a_num  <= n_a_num;
            r_a_den  <= n_a_den;
            r_a_side <= n_a_side;
        end
    end

    // main divider
    logic               d1_v, d2_rdy;
    logic [NUM_W-1:0]   d1_quo;
    logic [WHOLE_W-1:0] d1_rem;
    logic [SIDE_W-1:0]  d1_side;
    t_side2             d2_in;

    tfp_udiv #(
        .NW  (NUM_W),
        .DW  (WHOLE_W),
        .BPS (DIV_BITS_PER_STAGE),
        .SW  (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .o_ready (d1_rdy),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_side  (r_a_side),
        .o_valid (d1_v),
        .i_ready (d2_rdy),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    assign d2_in.s    = t_side'(d1_side);
    assign d2_in.q1   = d1_quo;
    assign d2_in.rem1 = d1_rem[TENTHS_W-1:0];

    // quotient split into whole part and tenths digit
    logic                d2_v, out_rdy;
    logic [NUM_W-1:0]    d2_quo;
    logic [TENTHS_W-1:0] d2_rem;
    logic [SIDE2_W-1:0]  d2_side;

    tfp_udiv #(
        .NW  (NUM_W),
        .DW  (TENTHS_W),
        .BPS (DEC_BPS),
        .SW  (SIDE2_W)
    ) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_v),
        .o_ready (d2_rdy),
        .i_num   (d1_quo),
        .i_den   (TENTHS_W'(DEC)),
        .i_side  (d2_in),
        .o_valid (d2_v),
        .i_ready (out_rdy),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // result register
    t_side2              fin;
    logic                r_o_v;
    logic [WHOLE_W-1:0]  r_o_whole, n_o_whole;
    logic [TENTHS_W-1:0] r_o_tenths, n_o_tenths;
    logic                r_o_ovf, n_o_ovf;
    logic                r_o_dbz, n_o_dbz;

    assign fin = t_side2'(d2_side);

    always_comb begin
        logic [PROD_W-1:0] w;
        w          = fin.s.prod + PROD_W'(fin.q1);
        n_o_whole  = fin.s.whole;
        n_o_tenths = fin.s.tenths;
        n_o_ovf    = fin.s.ovf;
        n_o_dbz    = fin.s.dbz;
        case (fin.s.op)
            OP_MUL_INT: begin
                n_o_whole  = w[WHOLE_W-1:0];
                n_o_tenths = fin.rem1;
                n_o_ovf    = |w[PROD_W-1:WHOLE_W];
            end
            OP_DIV_INT, OP_FROM_TENTHS: begin
                if (!fin.s.dbz) begin
                    n_o_whole  = d2_quo[WHOLE_W-1:0];
                    n_o_tenths = d2_rem;
                    n_o_ovf    = |d2_quo[NUM_W-1:WHOLE_W];
                end
            end
            default: begin
            end
        endcase
    end

    assign out_rdy = !r_o_v || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_rdy) begin
            r_o_v <= d2_v;
        end
        if (out_rdy && d2_v) begin
            r_o_whole  <= n_o_whole;
            r_o_tenths <= n_o_tenths;
            r_o_ovf    <= n_o_ovf;
            r_o_dbz    <= n_o_dbz;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {4'b0, r_o_tenths, r_o_whole};
    assign o_m_axis_tuser  = {r_o_dbz, r_o_ovf};

    // a zero divisor gives an all-zero result without overflow
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1])
            |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[0]))
        else $error("divide by zero result not cleared");

    // the tenths digit of every result is a decimal digit
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[35:32] <= 4'd9))
        else $error("tenths digit out of range");

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule
